// ----- rtl/gsa_pkg.sv -----
// Shared types and codes for the generational slot allocator.
// No dependencies; gsa_ctrl, gsa_datapath and the top level refer to this package by scoped names.
package gsa_pkg;

   localparam int GenWidth    = 16;
   localparam int IndexWidth  = 7;
   localparam int CountWidth  = 7;

   typedef enum logic [1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_RELEASE = 2'd1,
      FUNC_CHECK   = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_NO_FREE = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]            func;
      logic [IndexWidth-1:0] handle_index;
      logic [GenWidth-1:0]   handle_generation;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [IndexWidth-1:0] slot_handle;
      logic [GenWidth-1:0]   slot_generation;
      logic [CountWidth-1:0] free_left;
      logic [CountWidth-1:0] retired_total;
      logic [CountWidth-1:0] high_water;
   } rsp_type;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic lookup;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
   } stat_type;

endpackage

// ----- rtl/gsa_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/gsa_ctrl.sv -----
// Controller state machine for the slot allocator: clearing pass, accept, lookup, update.
// Depends on gsa_pkg.
module gsa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_func,
   input  gsa_pkg::stat_type stat,
   output gsa_pkg::cmd_type  cmd,
   output logic              busy
);

   typedef enum logic [3:0] {
      S_CLEAR  = 4'b0001,
      S_IDLE   = 4'b0010,
      S_LOOKUP = 4'b0100,
      S_UPDATE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               state_in = (req_func == gsa_pkg::FUNC_ALLOC) ? S_LOOKUP : S_UPDATE;
            end
         end
         S_LOOKUP: state_in = S_UPDATE;
         S_UPDATE: state_in = S_IDLE;
         default:  state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy           = (state_ff != S_IDLE);
   assign cmd.clear_step = (state_ff == S_CLEAR);
   assign cmd.load       = (state_ff == S_IDLE) && start;
   assign cmd.lookup     = (state_ff == S_LOOKUP);
   assign cmd.update     = (state_ff == S_UPDATE);

endmodule

// ----- rtl/gsa_datapath.sv -----
// Datapath of the slot allocator: slot table and free ring memories, pointers, counters.
// Depends on gsa_pkg and gsa_ram.
module gsa_datapath #(
   parameter int SLOTS   = 64,
   parameter int GEN_MAX = 65535
) (
   input  logic              clock,
   input  logic              reset,
   input  gsa_pkg::cmd_type  cmd,
   input  gsa_pkg::req_type  req_data,
   output gsa_pkg::stat_type stat,
   output logic              rsp_strobe,
   output gsa_pkg::rsp_type  rsp_data
);

   localparam int SW  = $clog2(SLOTS);
   localparam int CW  = $clog2(SLOTS + 1);
   localparam int AW  = (SW > gsa_pkg::IndexWidth) ? SW : gsa_pkg::IndexWidth;
   localparam int GW  = gsa_pkg::GenWidth;
   localparam int TW  = GW + 1;

   gsa_pkg::req_type req_ff;
   logic [SW-1:0]    slot_ff, slot_in;
   logic [SW-1:0]    head_ff, head_in;
   logic [SW-1:0]    tail_ff, tail_in;
   logic [SW-1:0]    clr_ff, clr_in;
   logic [CW-1:0]    free_ff, free_in;
   logic [CW-1:0]    retired_ff, retired_in;
   logic [CW-1:0]    high_ff, high_in;
   logic [1:0]       status_ff, status_in;
   logic [CW-1:0]    handle_ff, handle_in;
   logic [GW-1:0]    gen_ff, gen_in;
   logic             valid_ff;

   logic [AW-1:0]    idx_wide;
   logic [SW-1:0]    req_addr;
   logic [SW-1:0]    ring_rdata;
   logic [TW-1:0]    tbl_rdata;
   logic             tbl_alive;
   logic [GW-1:0]    tbl_gen;
   logic             handle_ok;
   logic [CW-1:0]    slot_plus1;

   logic             tbl_we;
   logic [SW-1:0]    tbl_waddr;
   logic [TW-1:0]    tbl_wdata;
   logic [SW-1:0]    tbl_raddr;
   logic             ring_we;
   logic [SW-1:0]    ring_waddr;
   logic [SW-1:0]    ring_wdata;

   assign idx_wide  = AW'(req_data.handle_index) - AW'(1);
   assign req_addr  = idx_wide[SW-1:0];
   assign tbl_raddr = cmd.lookup ? ring_rdata : req_addr;
   assign tbl_alive = tbl_rdata[TW-1];
   assign tbl_gen   = tbl_rdata[GW-1:0];
   assign slot_plus1 = CW'(slot_ff) + CW'(1);
   assign handle_ok = (req_ff.handle_index != '0)
                   && (32'(req_ff.handle_index) <= SLOTS)
                   && tbl_alive
                   && (tbl_gen == req_ff.handle_generation);
   assign stat.clear_done = (clr_ff == SW'(SLOTS - 1));

   gsa_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   gsa_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_addr (head_ff),
      .rd_data (ring_rdata)
   );

   always_comb begin
      slot_in    = slot_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      clr_in     = clr_ff;
      free_in    = free_ff;
      retired_in = retired_ff;
      high_in    = high_ff;
      status_in  = status_ff;
      handle_in  = handle_ff;
      gen_in     = gen_ff;
      tbl_we     = 1'b0;
      tbl_waddr  = slot_ff;
      tbl_wdata  = '0;
      ring_we    = 1'b0;
      ring_waddr = tail_ff;
      ring_wdata = slot_ff;

      if (cmd.clear_step) begin
         tbl_we     = 1'b1;
         tbl_waddr  = clr_ff;
         ring_we    = 1'b1;
         ring_waddr = clr_ff;
         ring_wdata = clr_ff;
         if (!stat.clear_done) clr_in = clr_ff + SW'(1);
      end

      if (cmd.load)   slot_in = req_addr;
      if (cmd.lookup) slot_in = ring_rdata;

      if (cmd.update) begin
         status_in = gsa_pkg::STATUS_OK;
         handle_in = '0;
         gen_in    = '0;
         unique case (req_ff.func)
            gsa_pkg::FUNC_ALLOC: begin
               if (free_ff == '0) begin
                  status_in = gsa_pkg::STATUS_NO_FREE;
               end else begin
                  head_in   = (head_ff == SW'(SLOTS - 1)) ? '0 : head_ff + SW'(1);
                  free_in   = free_ff - CW'(1);
                  tbl_we    = 1'b1;
                  tbl_wdata = {1'b1, tbl_gen};
                  if (slot_plus1 > high_ff) high_in = slot_plus1;
                  handle_in = slot_plus1;
                  gen_in    = tbl_gen;
               end
            end
            gsa_pkg::FUNC_RELEASE: begin
               if (!handle_ok) begin
                  status_in = gsa_pkg::STATUS_INVALID;
               end else begin
                  tbl_we = 1'b1;
                  if (tbl_gen >= GW'(GEN_MAX)) begin
                     tbl_wdata  = {1'b0, tbl_gen};
                     retired_in = retired_ff + CW'(1);
                  end else begin
                     tbl_wdata = {1'b0, tbl_gen + GW'(1)};
                     ring_we   = 1'b1;
                     tail_in   = (tail_ff == SW'(SLOTS - 1)) ? '0 : tail_ff + SW'(1);
                     if (32'(free_ff) < SLOTS) free_in = free_ff + CW'(1);
                  end
               end
            end
            default: begin
               if (!handle_ok) status_in = gsa_pkg::STATUS_INVALID;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         clr_ff     <= '0;
         free_ff    <= CW'(SLOTS);
         retired_ff <= '0;
         high_ff    <= '0;
         valid_ff   <= 1'b0;
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         clr_ff     <= clr_in;
         free_ff    <= free_in;
         retired_ff <= retired_in;
         high_ff    <= high_in;
         valid_ff   <= cmd.update;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      slot_ff   <= slot_in;
      status_ff <= status_in;
      handle_ff <= handle_in;
      gen_ff    <= gen_in;
   end

   assign rsp_strobe             = valid_ff;
   assign rsp_data.status        = status_ff;
   assign rsp_data.slot_handle   = gsa_pkg::IndexWidth'(handle_ff);
   assign rsp_data.slot_generation = gen_ff;
   assign rsp_data.free_left     = gsa_pkg::CountWidth'(free_ff);
   assign rsp_data.retired_total = gsa_pkg::CountWidth'(retired_ff);
   assign rsp_data.high_water    = gsa_pkg::CountWidth'(high_ff);

`ifndef ASSERT_OFF
   a_strobe_after_update: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> $past(cmd.update))
      else $error("response strobe without an update step");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(free_ff) + 32'(retired_ff)) <= SLOTS)
      else $error("free plus retired slots exceed pool size");

   a_high_bound: assert property (@(posedge clock) disable iff (reset)
      32'(high_ff) <= SLOTS)
      else $error("high-water mark beyond pool size");

   a_alloc_mark: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (status_ff == gsa_pkg::STATUS_OK) && (handle_ff != '0))
         |-> (high_ff >= handle_ff))
      else $error("allocated slot above high-water mark");
`endif

endmodule

// ----- rtl/generational_slot_allocator.sv -----
// Allocate: accept, lookup (registered free ring read), update (registered slot table read), then the
// registered result strobe; release and check: accept, update, then the strobe. busy drops with the
// strobe, so a new request is taken only once the previous one has produced its result.
// After reset a clearing pass fills the ring and clears the table, busy high.
// Results cannot be stalled. Depends on gsa_pkg, gsa_ctrl, gsa_datapath, gsa_ram.
module generational_slot_allocator #(
   parameter int SLOTS   = 64,
   parameter int GEN_MAX = 65535
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gsa_pkg::req_type req_data,
   output logic             rsp_strobe,
   output gsa_pkg::rsp_type rsp_data
);

   gsa_pkg::cmd_type  cmd;
   gsa_pkg::stat_type stat;

   gsa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_data.func),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   gsa_datapath #(.SLOTS(SLOTS), .GEN_MAX(GEN_MAX)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
